// ===== rtl/fssm_pkg.sv =====
// fssm_pkg: shared types, codes and helpers of the frame slot status manager
// used by the core and by the slot state memory
// no dependencies
package fssm_pkg;

    // field and register widths
    localparam int OPCODE_W      = 2;
    localparam int SLOT_IDX_W    = 4;
    localparam int STATUS_W      = 2;
    localparam int CNT_W         = 5;
    localparam int BUF_COUNT_MAX = (1 << CNT_W) - 1;

    localparam logic [CNT_W-1:0] BUF_COUNT_RESET = 5'd16;

    // per-slot status as held in the memory
    typedef enum logic [1:0] {
        SLOT_FREE          = 2'd0,
        SLOT_WITH_PRODUCER = 2'd1,
        SLOT_READY         = 2'd2,
        SLOT_TRANSMITTING  = 2'd3
    } slot_state_t;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PROD_ACQUIRE = 2'd0,
        OP_PROD_SUBMIT  = 2'd1,
        OP_CONS_ACQUIRE = 2'd2,
        OP_CONS_RELEASE = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK   = 2'd0,
        STATUS_NONE = 2'd1,
        STATUS_BAD  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DONE
    } fsm_state_t;

    // slot status an operation looks for
    function automatic slot_state_t wanted_state(opcode_t op);
        slot_state_t s;
        case (op)
            OP_PROD_ACQUIRE: s = SLOT_FREE;
            OP_PROD_SUBMIT:  s = SLOT_WITH_PRODUCER;
            OP_CONS_ACQUIRE: s = SLOT_READY;
            OP_CONS_RELEASE: s = SLOT_TRANSMITTING;
            default:         s = SLOT_FREE;
        endcase
        return s;
    endfunction

    // slot status after a successful operation
    function automatic slot_state_t moved_state(opcode_t op);
        slot_state_t s;
        case (op)
            OP_PROD_ACQUIRE: s = SLOT_WITH_PRODUCER;
            OP_PROD_SUBMIT:  s = SLOT_READY;
            OP_CONS_ACQUIRE: s = SLOT_TRANSMITTING;
            OP_CONS_RELEASE: s = SLOT_FREE;
            default:         s = SLOT_FREE;
        endcase
        return s;
    endfunction

    function automatic logic is_acquire(opcode_t op);
        return (op == OP_PROD_ACQUIRE) || (op == OP_CONS_ACQUIRE);
    endfunction

endpackage

// ===== rtl/fssm_slot_ram.sv =====
// fssm_slot_ram: slot status memory, one write and one registered read port
// entries never written since reset read as free through per-entry valid bits
// depends on fssm_pkg
module fssm_slot_ram #(
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  rd_en,
    input  logic [AW-1:0]         rd_addr,
    output fssm_pkg::slot_state_t rd_state,
    input  logic                  wr_en,
    input  logic [AW-1:0]         wr_addr,
    input  fssm_pkg::slot_state_t wr_state
);
    import fssm_pkg::*;

    slot_state_t       mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    slot_state_t       rd_data_reg;
    logic              rd_vld_reg;

    // written flags, cleared at reset
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            vld_reg <= '0;
        end else if (wr_en) begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // write port
    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_state;
        end
    end

    // registered read port
    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
            rd_vld_reg  <= vld_reg[rd_addr];
        end
    end

    assign rd_state = rd_vld_reg ? rd_data_reg : SLOT_FREE;

endmodule

// ===== rtl/frame_slot_status_manager_core.sv =====
// frame_slot_status_manager_core: top level of the frame slot status manager
// depends on fssm_pkg and fssm_slot_ram
// Slot states live in a one-read, one-write memory with a registered read port,
// scanned one entry per cycle. The block works on one operation at a time. Submit and
// release read their one slot in the scan state, then go to done; an index at or beyond
// the slot count goes straight to done without a read. An acquire scans the ring from
// its pointer until it finds a slot in the wanted state or has checked count slots,
// count being the effective buffer_count. The result sits in an output register, so a new
// operation is taken while the previous result still waits. After reset all slots read
// as free at once; there is no clearing pass.
module frame_slot_status_manager_core #(
    parameter int MAX_SLOTS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fssm_pkg::CNT_W-1:0]      cfg_data,
    // operation channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [fssm_pkg::OPCODE_W-1:0]   s_opcode,
    input  logic [fssm_pkg::SLOT_IDX_W-1:0] s_slot_index,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [fssm_pkg::STATUS_W-1:0]   m_status,
    output logic [fssm_pkg::SLOT_IDX_W-1:0] m_granted_slot
);
    import fssm_pkg::*;

    localparam int EFF_MAX = (MAX_SLOTS < BUF_COUNT_MAX) ? MAX_SLOTS : BUF_COUNT_MAX;
    localparam int SLOT_W  = $clog2(EFF_MAX);
    localparam int AW      = $clog2(MAX_SLOTS);

    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(EFF_MAX);

    // effective slot count for a written buffer_count
    function automatic logic [CNT_W-1:0] eff_count(logic [CNT_W-1:0] bc);
        logic [CNT_W-1:0] c;
        c = bc;
        if (c == '0) c = CNT_W'(1);
        if (c > CNT_MAX) c = CNT_MAX;
        return c;
    endfunction

    // next slot on the ring
    function automatic logic [SLOT_W-1:0] ring_next(logic [SLOT_W-1:0] i,
                                                    logic [CNT_W-1:0]  cnt);
        logic [CNT_W-1:0] n;
        n = CNT_W'(i) + CNT_W'(1);
        return (n >= cnt) ? '0 : SLOT_W'(n);
    endfunction

    fsm_state_t          state_reg, state_next;
    opcode_t             op_reg, op_next;
    logic [SLOT_IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0]    lim_reg, lim_next;
    logic [SLOT_W-1:0]   iss_addr_reg, iss_addr_next;
    logic [CNT_W-1:0]    iss_cnt_reg, iss_cnt_next;
    logic [CNT_W-1:0]    chk_cnt_reg, chk_cnt_next;
    logic                pend_reg, pend_next;
    logic [SLOT_W-1:0]   pend_addr_reg, pend_addr_next;
    logic                hit_reg, hit_next;
    logic [SLOT_W-1:0]   hit_addr_reg, hit_addr_next;
    logic [SLOT_W-1:0]   prod_ptr_reg, prod_ptr_next;
    logic [SLOT_W-1:0]   cons_ptr_reg, cons_ptr_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [SLOT_IDX_W-1:0] m_slot_reg, m_slot_next;

    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    slot_state_t         rd_state;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    slot_state_t         wr_state;

    // operation decode at the input
    opcode_t             in_op;
    logic                in_acq;
    logic [SLOT_W-1:0]   in_ptr;
    logic                in_idx_ok;

    assign in_op     = opcode_t'(s_opcode);
    assign in_acq    = is_acquire(in_op);
    assign in_ptr    = (in_op == OP_CONS_ACQUIRE) ? cons_ptr_reg : prod_ptr_reg;
    assign in_idx_ok = CNT_W'(s_slot_index) < cnt_reg;

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == FSM_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_granted_slot = m_slot_reg;

    fssm_slot_ram #(
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .clk      (aclk),
        .rst_n    (aresetn),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_state (rd_state),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_state (wr_state)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            pend_reg     <= 1'b0;
            hit_reg      <= 1'b0;
            prod_ptr_reg <= '0;
            cons_ptr_reg <= '0;
            cnt_reg      <= eff_count(BUF_COUNT_RESET);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            pend_reg     <= pend_next;
            hit_reg      <= hit_next;
            prod_ptr_reg <= prod_ptr_next;
            cons_ptr_reg <= cons_ptr_next;
            cnt_reg      <= cnt_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        lim_reg       <= lim_next;
        iss_addr_reg  <= iss_addr_next;
        iss_cnt_reg   <= iss_cnt_next;
        chk_cnt_reg   <= chk_cnt_next;
        pend_addr_reg <= pend_addr_next;
        hit_addr_reg  <= hit_addr_next;
        m_status_reg  <= m_status_next;
        m_slot_reg    <= m_slot_next;
    end

    // sequencer: start, scan with one read in flight, finish with write-back
    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        lim_next       = lim_reg;
        iss_addr_next  = iss_addr_reg;
        iss_cnt_next   = iss_cnt_reg;
        chk_cnt_next   = chk_cnt_reg;
        pend_next      = 1'b0;
        pend_addr_next = iss_addr_reg;
        hit_next       = hit_reg;
        hit_addr_next  = hit_addr_reg;
        prod_ptr_next  = prod_ptr_reg;
        cons_ptr_next  = cons_ptr_reg;
        cnt_next       = cnt_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_status_next  = m_status_reg;
        m_slot_next    = m_slot_reg;
        rd_en          = 1'b0;
        rd_addr        = AW'(iss_addr_reg);
        wr_en          = 1'b0;
        wr_addr        = AW'(hit_addr_reg);
        wr_state       = moved_state(op_reg);

        // configuration write
        if (cfg_valid) begin
            cnt_next = eff_count(cfg_data);
        end

        case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    op_next      = in_op;
                    idx_next     = s_slot_index;
                    iss_cnt_next = '0;
                    chk_cnt_next = '0;
                    hit_next     = 1'b0;
                    if (in_acq) begin
                        lim_next      = cnt_reg;
                        iss_addr_next = (CNT_W'(in_ptr) >= cnt_reg) ? '0 : in_ptr;
                        state_next    = FSM_SCAN;
                    end else begin
                        lim_next      = CNT_W'(1);
                        iss_addr_next = SLOT_W'(s_slot_index);
                        state_next    = in_idx_ok ? FSM_SCAN : FSM_DONE;
                    end
                end
            end

            FSM_SCAN: begin
                // issue the next read while slots remain
                if (iss_cnt_reg < lim_reg) begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    iss_addr_next  = ring_next(iss_addr_reg, cnt_reg);
                    iss_cnt_next   = iss_cnt_reg + CNT_W'(1);
                end
                // check the slot read last cycle
                if (pend_reg) begin
                    if (rd_state == wanted_state(op_reg)) begin
                        hit_next      = 1'b1;
                        hit_addr_next = pend_addr_reg;
                        state_next    = FSM_DONE;
                    end else begin
                        chk_cnt_next = chk_cnt_reg + CNT_W'(1);
                        if (chk_cnt_next == lim_reg) begin
                            state_next = FSM_DONE;
                        end
                    end
                end
            end

            FSM_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (hit_reg) begin
                        m_status_next = STATUS_OK;
                    end else if (is_acquire(op_reg)) begin
                        m_status_next = STATUS_NONE;
                    end else begin
                        m_status_next = STATUS_BAD;
                    end
                    if (is_acquire(op_reg)) begin
                        m_slot_next = hit_reg ? SLOT_IDX_W'(hit_addr_reg) : '0;
                    end else begin
                        m_slot_next = idx_reg;
                    end
                    // write back the moved slot on a hit and, for an acquire, advance its ring pointer
                    wr_en = hit_reg;
                    if (hit_reg && (op_reg == OP_PROD_ACQUIRE)) begin
                        prod_ptr_next = ring_next(hit_addr_reg, cnt_reg);
                    end
                    if (hit_reg && (op_reg == OP_CONS_ACQUIRE)) begin
                        cons_ptr_next = ring_next(hit_addr_reg, cnt_reg);
                    end
                    state_next = FSM_IDLE;
                end
            end

            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/fssm_checker.sv =====
// fssm_checker: port-level checks of the frame slot status manager core
// depends on fssm_pkg; bound to frame_slot_status_manager_core below
module fssm_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [fssm_pkg::STATUS_W-1:0]   m_status,
    input logic [fssm_pkg::SLOT_IDX_W-1:0] m_granted_slot
);
    import fssm_pkg::*;

    // a stalled result holds
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_granted_slot))
        else $error("result changed while stalled");

    // one operation at a time: no transfer in the cycle after one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an operation is in progress");

    // a failed acquire grants slot zero
    a_none_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_NONE) |-> m_granted_slot == '0)
        else $error("failed acquire reports a nonzero slot");

    // reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

endmodule

bind frame_slot_status_manager_core fssm_checker u_fssm_checker (.*);
